/* sv/owtr_pkg.sv */
package owtr_pkg;

  localparam int RomBytes = 8;
  localparam int AddrW    = 6;

  localparam logic [7:0] CmdMatch   = 8'h55;
  localparam logic [7:0] CmdSkip    = 8'hCC;
  localparam logic [7:0] CmdConvert = 8'h44;
  localparam logic [7:0] CmdRead    = 8'hBE;

  // Index of the function command byte that closes an addressing sequence.
  localparam logic [3:0] LastSkipIdx  = 4'd1;
  localparam logic [3:0] LastMatchIdx = 4'(RomBytes + 1);

  typedef enum logic [2:0] {
    REG_ROM_A,
    REG_ROM_B,
    REG_RESET_LOW,
    REG_PRES_WAIT,
    REG_RECOVERY,
    REG_SLOT,
    REG_GAP
  } reg_idx_t;

  typedef struct packed {
    logic [63:0] rom_code_a;
    logic [63:0] rom_code_b;
    logic [15:0] reset_low_ticks;
    logic [15:0] presence_wait_ticks;
    logic [15:0] recovery_ticks;
    logic [15:0] slot_ticks;
    logic [15:0] gap_ticks;
  } owtr_cfg_t;

  typedef struct packed {
    logic start_req;
    logic skip_rom;
    logic sensor_sel;
    logic line_in;
  } owtr_in_t;

  typedef struct packed {
    logic        drive_low;
    logic        busy_res;
    logic        done_res;
    logic        presence;
    logic [15:0] temp_tenths;
  } owtr_out_t;

endpackage

/* sv/owtr_cfg_regs.sv */
module owtr_cfg_regs
  import owtr_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [63:0]      pwdata,
  output logic [63:0]      prdata,
  output logic             pready,
  output owtr_cfg_t        cfg
);

  owtr_cfg_t cfg_r;
  reg_idx_t  idx;
  logic      wr_en;

  assign idx    = reg_idx_t'(paddr[AddrW-1:3]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rom_code_a          <= 64'd1369094298310791208;
      cfg_r.rom_code_b          <= 64'd16212958670126472744;
      cfg_r.reset_low_ticks     <= 16'd80;
      cfg_r.presence_wait_ticks <= 16'd14;
      cfg_r.recovery_ticks      <= 16'd20;
      cfg_r.slot_ticks          <= 16'd5;
      cfg_r.gap_ticks           <= 16'd4;
    end else if (wr_en) begin
      case (idx)
        REG_ROM_A:     cfg_r.rom_code_a          <= pwdata;
        REG_ROM_B:     cfg_r.rom_code_b          <= pwdata;
        REG_RESET_LOW: cfg_r.reset_low_ticks     <= pwdata[15:0];
        REG_PRES_WAIT: cfg_r.presence_wait_ticks <= pwdata[15:0];
        REG_RECOVERY:  cfg_r.recovery_ticks      <= pwdata[15:0];
        REG_SLOT:      cfg_r.slot_ticks          <= pwdata[15:0];
        REG_GAP:       cfg_r.gap_ticks           <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_ROM_A:     prdata = cfg_r.rom_code_a;
      REG_ROM_B:     prdata = cfg_r.rom_code_b;
      REG_RESET_LOW: prdata = {48'd0, cfg_r.reset_low_ticks};
      REG_PRES_WAIT: prdata = {48'd0, cfg_r.presence_wait_ticks};
      REG_RECOVERY:  prdata = {48'd0, cfg_r.recovery_ticks};
      REG_SLOT:      prdata = {48'd0, cfg_r.slot_ticks};
      REG_GAP:       prdata = {48'd0, cfg_r.gap_ticks};
      default:       prdata = 64'd0;
    endcase
  end

endmodule

/* sv/owtr_seq.sv */
module owtr_seq
  import owtr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      acc,
  input  owtr_in_t  item,
  input  owtr_cfg_t cfg,
  output owtr_out_t res
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_RST_LOW,
    PH_PRES_WAIT,
    PH_RECOVER,
    PH_WR_BIT,
    PH_WR_GAP,
    PH_RD_BIT
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [16:0] tick_count_r, tick_count_nxt;
  logic [2:0]  bit_index_r, bit_index_nxt;
  logic [3:0]  byte_index_r, byte_index_nxt;
  logic [7:0]  shift_byte_r, shift_byte_nxt;
  logic [7:0]  low_byte_r, low_byte_nxt;
  logic        pass_two_r, pass_two_nxt;
  logic        presence_r, presence_nxt;
  logic [15:0] result_r, result_nxt;
  logic        skip_r, skip_nxt;
  logic        sel_r, sel_nxt;

  logic        drive, busy, done, do_next;
  logic [16:0] tick_inc;
  logic [3:0]  last_idx;
  logic [7:0]  byte_first, byte_next;
  logic [7:0]  sb_rd;
  logic [19:0] scaled;
  logic [15:0] tenths;

  function automatic logic [15:0] at_least_one(input logic [15:0] v);
    return (v == 16'd0) ? 16'd1 : v;
  endfunction

  function automatic logic [7:0] byte_for(input logic [3:0] idx, input logic [3:0] last,
                                          input logic skip, input logic sel,
                                          input logic second, input logic [63:0] code_a,
                                          input logic [63:0] code_b);
    logic [63:0] code;
    logic [2:0]  sh;
    code = sel ? code_b : code_a;
    sh   = 3'(idx - 4'd1);
    if (idx == 4'd0) return skip ? CmdSkip : CmdMatch;
    else if (idx >= last) return second ? CmdRead : CmdConvert;
    else return code[{sh, 3'b000} +: 8];
  endfunction

  assign tick_inc   = tick_count_r + 17'd1;
  assign last_idx   = skip_r ? LastSkipIdx : LastMatchIdx;
  assign byte_first = byte_for(4'd0, last_idx, skip_r, sel_r, pass_two_r,
                               cfg.rom_code_a, cfg.rom_code_b);
  assign byte_next  = byte_for(byte_index_r + 4'd1, last_idx, skip_r, sel_r, pass_two_r,
                               cfg.rom_code_a, cfg.rom_code_b);

  // The read sample lands on the second tick of a read slot.
  assign sb_rd  = shift_byte_r |
                  ((tick_count_r == 17'd1) ? (8'(item.line_in) << bit_index_r) : 8'd0);
  // raw * 10 + 8, then divide by 16: rounds raw / 16 degrees to tenths.
  assign scaled = ({4'd0, sb_rd, low_byte_r} << 3) + ({4'd0, sb_rd, low_byte_r} << 1)
                  + 20'd8;
  assign tenths = scaled[19:4];

  always_comb begin
    phase_nxt      = phase_r;
    tick_count_nxt = tick_count_r;
    bit_index_nxt  = bit_index_r;
    byte_index_nxt = byte_index_r;
    shift_byte_nxt = shift_byte_r;
    low_byte_nxt   = low_byte_r;
    pass_two_nxt   = pass_two_r;
    presence_nxt   = presence_r;
    result_nxt     = result_r;
    skip_nxt       = skip_r;
    sel_nxt        = sel_r;
    drive          = 1'b0;
    busy           = 1'b1;
    done           = 1'b0;
    do_next        = 1'b0;

    case (phase_r)
      PH_RST_LOW: begin
        drive = 1'b1;
        if (tick_inc >= {1'b0, at_least_one(cfg.reset_low_ticks)}) begin
          phase_nxt      = PH_PRES_WAIT;
          tick_count_nxt = 17'd0;
        end else begin
          tick_count_nxt = tick_inc;
        end
      end
      PH_PRES_WAIT: begin
        if (tick_inc >= {1'b0, at_least_one(cfg.presence_wait_ticks)}) begin
          presence_nxt   = ~item.line_in;
          phase_nxt      = PH_RECOVER;
          tick_count_nxt = 17'd0;
        end else begin
          tick_count_nxt = tick_inc;
        end
      end
      PH_RECOVER: begin
        if (tick_inc >= {1'b0, at_least_one(cfg.recovery_ticks)}) begin
          byte_index_nxt = 4'd0;
          bit_index_nxt  = 3'd0;
          shift_byte_nxt = byte_first;
          phase_nxt      = PH_WR_BIT;
          tick_count_nxt = 17'd0;
        end else begin
          tick_count_nxt = tick_inc;
        end
      end
      PH_WR_BIT: begin
        if (tick_count_r == 17'd0) begin
          drive = 1'b1;
        end else if (tick_count_r < {1'b0, at_least_one(cfg.slot_ticks)}) begin
          drive = ~shift_byte_r[bit_index_r];
        end
        if (tick_count_r >= {1'b0, at_least_one(cfg.slot_ticks)}) begin
          if (bit_index_r != 3'd7) begin
            bit_index_nxt  = bit_index_r + 3'd1;
            tick_count_nxt = 17'd0;
          end else begin
            bit_index_nxt = 3'd0;
            if (cfg.gap_ticks != 16'd0) begin
              phase_nxt      = PH_WR_GAP;
              tick_count_nxt = 17'd0;
            end else begin
              do_next = 1'b1;
            end
          end
        end else begin
          tick_count_nxt = tick_inc;
        end
      end
      PH_WR_GAP: begin
        if (tick_inc >= {1'b0, cfg.gap_ticks}) begin
          do_next = 1'b1;
        end else begin
          tick_count_nxt = tick_inc;
        end
      end
      PH_RD_BIT: begin
        if (tick_count_r == 17'd0) begin
          drive          = 1'b1;
          tick_count_nxt = 17'd1;
        end else begin
          shift_byte_nxt = sb_rd;
          if (tick_count_r >= 17'd1 + {1'b0, cfg.gap_ticks}) begin
            if (bit_index_r != 3'd7) begin
              bit_index_nxt  = bit_index_r + 3'd1;
              tick_count_nxt = 17'd0;
            end else if (byte_index_r == 4'd0) begin
              low_byte_nxt   = sb_rd;
              shift_byte_nxt = 8'd0;
              bit_index_nxt  = 3'd0;
              byte_index_nxt = 4'd1;
              tick_count_nxt = 17'd0;
            end else begin
              result_nxt     = tenths;
              done           = 1'b1;
              pass_two_nxt   = 1'b0;
              bit_index_nxt  = 3'd0;
              byte_index_nxt = 4'd0;
              phase_nxt      = PH_IDLE;
              tick_count_nxt = 17'd0;
            end
          end else begin
            tick_count_nxt = tick_inc;
          end
        end
      end
      default: begin
        busy      = 1'b0;
        phase_nxt = PH_IDLE;
        if (item.start_req) begin
          skip_nxt       = item.skip_rom;
          sel_nxt        = item.sensor_sel;
          pass_two_nxt   = 1'b0;
          bit_index_nxt  = 3'd0;
          byte_index_nxt = 4'd0;
          shift_byte_nxt = 8'd0;
          phase_nxt      = PH_RST_LOW;
          tick_count_nxt = 17'd0;
        end
      end
    endcase

    // End of a written byte: next byte, second pass, or start of the read.
    if (do_next) begin
      bit_index_nxt  = 3'd0;
      tick_count_nxt = 17'd0;
      if (byte_index_r < last_idx) begin
        byte_index_nxt = byte_index_r + 4'd1;
        shift_byte_nxt = byte_next;
        phase_nxt      = PH_WR_BIT;
      end else if (!pass_two_r) begin
        pass_two_nxt = 1'b1;
        phase_nxt    = PH_RST_LOW;
      end else begin
        byte_index_nxt = 4'd0;
        shift_byte_nxt = 8'd0;
        phase_nxt      = PH_RD_BIT;
      end
    end
  end

  assign res.drive_low   = drive;
  assign res.busy_res    = busy;
  assign res.done_res    = done;
  assign res.presence    = presence_nxt;
  assign res.temp_tenths = result_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      tick_count_r <= 17'd0;
      bit_index_r  <= 3'd0;
      byte_index_r <= 4'd0;
      shift_byte_r <= 8'd0;
      low_byte_r   <= 8'd0;
      pass_two_r   <= 1'b0;
      presence_r   <= 1'b0;
      result_r     <= 16'd0;
      skip_r       <= 1'b0;
      sel_r        <= 1'b0;
    end else if (acc) begin
      phase_r      <= phase_nxt;
      tick_count_r <= tick_count_nxt;
      bit_index_r  <= bit_index_nxt;
      byte_index_r <= byte_index_nxt;
      shift_byte_r <= shift_byte_nxt;
      low_byte_r   <= low_byte_nxt;
      pass_two_r   <= pass_two_nxt;
      presence_r   <= presence_nxt;
      result_r     <= result_nxt;
      skip_r       <= skip_nxt;
      sel_r        <= sel_nxt;
    end
  end

`ifndef SYNTHESIS
  a_done_is_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && res.done_res) |-> res.busy_res)
    else $error("done reported on a tick that is not busy");

  a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && res.done_res) |=> (phase_r == PH_IDLE))
    else $error("sequencer did not return to idle after a result");

  a_byte_bound: assert property (@(posedge clk) disable iff (!rst_n)
    byte_index_r <= LastMatchIdx)
    else $error("byte index ran past the addressing sequence");
`endif

endmodule

/* sv/owtr_out_buf.sv */
module owtr_out_buf
  import owtr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      acc,
  input  owtr_out_t res,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output owtr_out_t out_data
);

  owtr_out_t out_r;
  owtr_out_t skid_r;
  logic      out_valid_r;
  logic      skid_valid_r;

  // The skid stage catches a transaction accepted while the output is stalled.
  assign in_ready  = ~skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) begin
        if (skid_valid_r) begin
          out_r        <= skid_r;
          skid_valid_r <= 1'b0;
        end else if (acc) begin
          out_r <= res;
        end else begin
          out_valid_r <= 1'b0;
        end
      end else if (!out_valid_r) begin
        if (acc) begin
          out_r       <= res;
          out_valid_r <= 1'b1;
        end
      end else if (acc) begin
        skid_r       <= res;
        skid_valid_r <= 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid stage holds a transaction ahead of the output");

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready && acc) |=> skid_valid_r)
    else $error("transaction accepted under stall was not captured");

  a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && out_ready) |=> (!skid_valid_r && out_valid_r))
    else $error("skid stage did not drain into the output");
`endif

endmodule

/* sv/onewire_temperature_reader_unit.sv */
// Channel  | Handshake                  | Payload
// in_      | in_valid / in_ready        | in_data  (owtr_in_t: one bus tick)
// out_     | out_valid / out_ready      | out_data (owtr_out_t: drive and status)
// cfg      | psel, penable, pwrite      | paddr, pwdata, prdata (64-bit data bus)
//
// One tick transaction is processed per clock while in_ready is high; its result
// is registered in the output register, or in the skid while out_ready stalls.
// The sequencer state advances only on an accepted transaction, so stalls on
// the input side freeze the bus timing.
// A two-entry output stage (output register plus skid) keeps in_ready high
// while the skid is empty; a transaction accepted under an out_ready stall
// fills the skid; in_ready stays low until it drains into the output register.
// rst_n is synchronous and active low; it restores the register defaults.
module onewire_temperature_reader_unit
  import owtr_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  owtr_in_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output owtr_out_t        out_data,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [63:0]      pwdata,
  output logic [63:0]      prdata,
  output logic             pready
);

  owtr_cfg_t cfg;
  owtr_out_t res;
  logic      acc;

  assign acc = in_valid & in_ready;

  owtr_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  owtr_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .acc   (acc),
    .item  (in_data),
    .cfg   (cfg),
    .res   (res)
  );

  owtr_out_buf u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .res       (res),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
